// File: hdl/sfcp_pkg.sv
// Shared types and constants for the sync frame checksum parser.
// No dependencies; used by the controller, the datapath and the top level.
package sfcp_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_INVERT      = 2'd0;
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd1;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd2;

    // Frame layout
    localparam int NUM_TEMPS = 6;
    localparam int TEMP_BASE = 5;
    localparam int RELAY_POS = 20;

    localparam logic [7:0] INVERT_MASK = 8'hFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMP_FIRST,
        ST_RESYNC,
        ST_CMP_SECOND,
        ST_SUM,
        ST_SUM_END,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // write the request byte into the buffer
        logic rd_head;    // read the first held byte
        logic rd_second;  // read the second held byte
        logic drop;       // drop the first held byte
        logic sum_start;  // clear the checksum sweep
        logic sum_rd;     // read the next byte of the sweep
        logic emit;       // load the result register and empty the buffer
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic cnt_ge2;
        logic full;
        logic match_first;
        logic match_second;
        logic sum_last_issue;
        logic sum_ok;
        logic out_free;
    } status_t;

endpackage

// File: hdl/sfcp_ctrl.sv
// Sequencer for the sync frame checksum parser: resync, sync check, checksum sweep.
// Depends on sfcp_pkg for the state, command and status types.
module sfcp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  sfcp_pkg::status_t status,
    output sfcp_pkg::cmd_t    cmd
);

    sfcp_pkg::state_t state_reg;
    sfcp_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfcp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfcp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sfcp_pkg::ST_CHECK;
                end
            end
            sfcp_pkg::ST_CHECK:
            begin
                if (status.cnt_ge2)
                begin
                    state_next = sfcp_pkg::ST_CMP_FIRST;
                end
                else
                begin
                    state_next = sfcp_pkg::ST_IDLE;
                end
            end
            sfcp_pkg::ST_CMP_FIRST:
            begin
                if (!status.match_first)
                begin
                    state_next = sfcp_pkg::ST_RESYNC;
                end
                else if (status.cnt_ge2)
                begin
                    state_next = sfcp_pkg::ST_CMP_SECOND;
                end
                else
                begin
                    state_next = sfcp_pkg::ST_IDLE;
                end
            end
            sfcp_pkg::ST_RESYNC:
            begin
                if (status.cnt_zero)
                begin
                    state_next = sfcp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = sfcp_pkg::ST_CMP_FIRST;
                end
            end
            sfcp_pkg::ST_CMP_SECOND:
            begin
                if (status.match_second && status.full)
                begin
                    state_next = sfcp_pkg::ST_SUM;
                end
                else
                begin
                    state_next = sfcp_pkg::ST_IDLE;
                end
            end
            sfcp_pkg::ST_SUM:
            begin
                if (status.sum_last_issue)
                begin
                    state_next = sfcp_pkg::ST_SUM_END;
                end
            end
            sfcp_pkg::ST_SUM_END:
            begin
                state_next = sfcp_pkg::ST_DECIDE;
            end
            sfcp_pkg::ST_DECIDE:
            begin
                if (status.sum_ok)
                begin
                    state_next = sfcp_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = sfcp_pkg::ST_IDLE;
                end
            end
            sfcp_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = sfcp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfcp_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            sfcp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            sfcp_pkg::ST_CHECK:
            begin
                cmd.rd_head = status.cnt_ge2;
            end
            sfcp_pkg::ST_CMP_FIRST:
            begin
                cmd.drop      = !status.match_first;
                cmd.rd_second = status.match_first && status.cnt_ge2;
            end
            sfcp_pkg::ST_RESYNC:
            begin
                cmd.rd_head = !status.cnt_zero;
            end
            sfcp_pkg::ST_CMP_SECOND:
            begin
                cmd.drop      = !status.match_second;
                cmd.sum_start = status.match_second && status.full;
            end
            sfcp_pkg::ST_SUM:
            begin
                cmd.sum_rd = 1'b1;
            end
            sfcp_pkg::ST_SUM_END:
            begin
                cmd = '0;
            end
            sfcp_pkg::ST_DECIDE:
            begin
                cmd.drop = !status.sum_ok;
            end
            sfcp_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/sfcp_datapath.sv
// Datapath for the sync frame checksum parser: configuration, circular frame
// buffer, checksum sweep and result register. Depends on sfcp_pkg.
module sfcp_datapath
#(
    parameter int FRAME_LEN = 22
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic [7:0]        rx_byte,
    input  sfcp_pkg::cmd_t    cmd,
    output sfcp_pkg::status_t status,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       temp_0,
    output logic [15:0]       temp_1,
    output logic [15:0]       temp_2,
    output logic [15:0]       temp_3,
    output logic [15:0]       temp_4,
    output logic [15:0]       temp_5,
    output logic [7:0]        relay_bits,
    output logic              relay_bits_present
);

    localparam int AW = $clog2(FRAME_LEN);
    localparam int CW = $clog2(FRAME_LEN + 1);
    localparam logic [AW:0]   LEN_W    = (AW + 1)'(FRAME_LEN);
    localparam logic [CW-1:0] LEN_C    = CW'(FRAME_LEN);
    localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_LEN - 1);
    localparam logic          HAS_RELAY = (FRAME_LEN > sfcp_pkg::RELAY_POS);

    // Add an offset to a buffer position, wrapping at the frame length
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= LEN_W)
        begin
            s = s - LEN_W;
        end
        return s[AW-1:0];
    endfunction

    logic            invert_reg;
    logic [7:0]      sync_first_reg;
    logic [7:0]      sync_second_reg;

    logic [7:0]      mem [FRAME_LEN];
    logic [AW-1:0]   head_reg;
    logic [CW-1:0]   count_reg;
    logic [7:0]      rd_data_reg;
    logic [AW-1:0]   idx_reg;
    logic            rd_valid_reg;
    logic [AW-1:0]   rd_idx_reg;
    logic [7:0]      sum_reg;
    logic            sum_ok_reg;
    logic [15:0]     temp_stage [sfcp_pkg::NUM_TEMPS];
    logic [7:0]      relay_stage;
    logic [15:0]     temp_reg [sfcp_pkg::NUM_TEMPS];
    logic [7:0]      relay_reg;
    logic            out_valid_reg;

    logic            full;
    logic [7:0]      byte_in;
    logic [AW-1:0]   head_inc;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic            rd_en;

    assign full     = (count_reg == LEN_C);
    assign byte_in  = rx_byte ^ (invert_reg ? sfcp_pkg::INVERT_MASK : 8'h00);
    assign head_inc = wrap_add(head_reg, AW'(1));
    assign wr_addr  = full ? head_reg : wrap_add(head_reg, count_reg[AW-1:0]);
    assign rd_en    = cmd.rd_head | cmd.rd_second | cmd.sum_rd;

    // Select the read address
    always_comb
    begin
        rd_addr = head_reg;
        if (cmd.rd_second)
        begin
            rd_addr = head_inc;
        end
        else if (cmd.sum_rd)
        begin
            rd_addr = wrap_add(head_reg, idx_reg);
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg      <= 1'b0;
            sync_first_reg  <= 8'h00;
            sync_second_reg <= 8'h00;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfcp_pkg::CFG_INVERT:      invert_reg      <= cfg_data[0];
                sfcp_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                sfcp_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:                   invert_reg      <= invert_reg;
            endcase
        end
    end

    // Frame buffer memory
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[wr_addr] <= byte_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Head pointer and fill count; a full buffer overwrites its oldest byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (full)
            begin
                head_reg <= head_inc;
            end
            else
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
        else if (cmd.drop)
        begin
            head_reg  <= head_inc;
            count_reg <= count_reg - CW'(1);
        end
        else if (cmd.emit)
        begin
            count_reg <= '0;
        end
    end

    // Sweep index and read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
            sum_reg      <= 8'h00;
            sum_ok_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.sum_rd;
            rd_idx_reg   <= idx_reg;
            if (cmd.sum_start)
            begin
                idx_reg <= '0;
                sum_reg <= 8'h00;
            end
            else if (cmd.sum_rd)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            // Accumulate every byte but the last, then compare against it
            if (rd_valid_reg)
            begin
                if (rd_idx_reg == LAST_IDX)
                begin
                    sum_ok_reg <= (sum_reg == rd_data_reg);
                end
                else
                begin
                    sum_reg <= sum_reg + rd_data_reg;
                end
            end
        end
    end

    // Capture payload bytes as the sweep passes them
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            for (int k = 0; k < sfcp_pkg::NUM_TEMPS; k++)
            begin
                if (rd_idx_reg == AW'(sfcp_pkg::TEMP_BASE + 2 * k))
                begin
                    temp_stage[k][15:8] <= rd_data_reg;
                end
                if (rd_idx_reg == AW'(sfcp_pkg::TEMP_BASE + 2 * k + 1))
                begin
                    temp_stage[k][7:0] <= rd_data_reg;
                end
            end
            if (HAS_RELAY && (rd_idx_reg == AW'(sfcp_pkg::RELAY_POS)))
            begin
                relay_stage <= rd_data_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            for (int k = 0; k < sfcp_pkg::NUM_TEMPS; k++)
            begin
                temp_reg[k] <= temp_stage[k];
            end
            relay_reg <= relay_stage;
        end
    end

    assign out_valid          = out_valid_reg;
    assign temp_0             = temp_reg[0];
    assign temp_1             = temp_reg[1];
    assign temp_2             = temp_reg[2];
    assign temp_3             = temp_reg[3];
    assign temp_4             = temp_reg[4];
    assign temp_5             = temp_reg[5];
    assign relay_bits         = HAS_RELAY ? relay_reg : 8'h00;
    assign relay_bits_present = HAS_RELAY;

    // Status to the controller
    assign status.cnt_zero       = (count_reg == '0);
    assign status.cnt_ge2        = (count_reg >= CW'(2));
    assign status.full           = full;
    assign status.match_first    = (rd_data_reg == sync_first_reg);
    assign status.match_second   = (rd_data_reg == sync_second_reg);
    assign status.sum_last_issue = (idx_reg == LAST_IDX);
    assign status.sum_ok         = sum_ok_reg;
    assign status.out_free       = !out_valid_reg || !out_stall;

endmodule

// File: hdl/sync_frame_checksum_parser_unit.sv
// Top level of the sync frame checksum parser.
// Instantiates sfcp_ctrl and sfcp_datapath; depends on sfcp_pkg.
//
// Takes one received byte per request, optionally inverted, into a circular
// buffer of FRAME_LEN bytes, drops leading bytes until the buffer starts with
// the two sync bytes, and once full checks the last byte against the 8-bit sum
// of the others. A good frame gives one result (six big-endian temperatures
// and the relay byte) and empties the buffer. Bytes are handled one at a time:
// in_stall is high while a byte is being worked on. A byte that leaves fewer
// than two bytes held is accepted and the count checked. Otherwise the first
// sync compare follows (accept, memory read, compare), each dropped leading
// byte adds a drop and a fresh read of the new head, and the second sync
// compare follows. A full buffer adds a checksum sweep (one read per byte,
// the last byte landing, a decision) through the single buffer read port,
// and then loads the result register. The result register holds a result
// until it is taken, so the next byte is accepted meanwhile; a second result
// waits for it to drain.
module sync_frame_checksum_parser_unit
#(
    parameter int FRAME_LEN = 22
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] temp_0,
    output logic [15:0] temp_1,
    output logic [15:0] temp_2,
    output logic [15:0] temp_3,
    output logic [15:0] temp_4,
    output logic [15:0] temp_5,
    output logic [7:0]  relay_bits,
    output logic        relay_bits_present
);

    sfcp_pkg::cmd_t    cmd;
    sfcp_pkg::status_t status;

    sfcp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sfcp_datapath
    #(
        .FRAME_LEN (FRAME_LEN)
    )
    u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .rx_byte            (rx_byte),
        .cmd                (cmd),
        .status             (status),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .temp_0             (temp_0),
        .temp_1             (temp_1),
        .temp_2             (temp_2),
        .temp_3             (temp_3),
        .temp_4             (temp_4),
        .temp_5             (temp_5),
        .relay_bits         (relay_bits),
        .relay_bits_present (relay_bits_present)
    );

    // An accepted request always keeps the block busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("block took a second request back to back");

    // At most one buffer update per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.drop, cmd.emit, cmd.sum_start}))
    else $error("conflicting buffer commands");

    // A result is only loaded from a full buffer whose checksum matched
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (status.sum_ok && status.full && status.out_free))
    else $error("result loaded without a checked frame");

    // A new result appears only while the block is busy with a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule
